// ===== rtl/battery_level_estimator_macros.svh =====
// ----------------------------------------------------------------------------
// Battery level estimator assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef BATTERY_LEVEL_ESTIMATOR_MACROS_SVH
`define BATTERY_LEVEL_ESTIMATOR_MACROS_SVH

// Same-cycle implication, clocked on aclk, quiet during reset.
`define BLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, quiet during reset.
`define BLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ble_pkg.sv =====
// ----------------------------------------------------------------------------
// ble_pkg
// Widths, constants, microcode encoding and control program of the
// battery level estimator.
// ----------------------------------------------------------------------------
package ble_pkg;

    localparam int SAMPLE_W = 12;          // ADC sample port
    localparam int CFG_W    = 13;          // millivolt registers
    localparam int TICKS_W  = 10;          // stable_ticks / repeat counter
    localparam int LEVEL_W  = 8;           // internal percent, saturates at 255
    localparam int PCT_W    = 7;           // reported percent
    localparam int PROD_W   = 2 * CFG_W;   // multiplier product / dividend
    localparam int STEP_W   = 4;           // microprogram counter
    localparam int REG_IDX_W = 2;

    localparam int MAX_BURST_DEF   = 32;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam logic [CFG_W-1:0]   MV_MAX     = 13'd8191;
    localparam logic [LEVEL_W-1:0] LEVEL_SAT  = 8'd255;
    localparam logic [CFG_W-1:0]   PCT_FULL   = 13'd100;
    localparam logic [TICKS_W-1:0] REPEAT_MAX = 10'd1023;

    localparam logic [CFG_W-1:0]   FULL_SCALE_RST = 13'd6600;
    localparam logic [CFG_W-1:0]   EMPTY_RST      = 13'd3200;
    localparam logic [CFG_W-1:0]   FULL_RST       = 13'd4200;
    localparam logic [TICKS_W-1:0] TICKS_RST      = 10'd10;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FULL_SCALE = 2'd0,
        REG_EMPTY      = 2'd1,
        REG_FULL       = 2'd2,
        REG_TICKS      = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCUM,       // take samples
        OP_DIV_AVG,     // sum / count
        OP_MUL_MV,      // avg * full_scale
        OP_DIV_MV,      // / ADC_MAX
        OP_SET_MV,
        OP_MUL_FIRST,   // mv * 100
        OP_DIV_FIRST,   // / full_mv
        OP_SET_FIRST,
        OP_MUL_CAND,    // (mv - empty) * 100
        OP_DIV_CAND,    // / (full - empty)
        OP_SET_CAND,
        OP_OUTPUT
    } op_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_START,
        COND_DIV_BUSY,
        COND_FIRST_DONE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    // sequencer -> datapath
    typedef struct packed {
        op_t  op;
        logic idle;
    } ctrl_t;

    // datapath / divider -> sequencer
    typedef struct packed {
        logic start;
        logic div_busy;
        logic first_done;
        logic out_busy;
    } status_t;

    localparam logic [STEP_W-1:0] ST_IDLE       = 4'd0;
    localparam logic [STEP_W-1:0] ST_AVG_DIV    = 4'd1;
    localparam logic [STEP_W-1:0] ST_AVG_WAIT   = 4'd2;
    localparam logic [STEP_W-1:0] ST_MV_MUL     = 4'd3;
    localparam logic [STEP_W-1:0] ST_MV_DIV     = 4'd4;
    localparam logic [STEP_W-1:0] ST_MV_WAIT    = 4'd5;
    localparam logic [STEP_W-1:0] ST_MV_SET     = 4'd6;
    localparam logic [STEP_W-1:0] ST_FIRST_MUL  = 4'd7;
    localparam logic [STEP_W-1:0] ST_FIRST_DIV  = 4'd8;
    localparam logic [STEP_W-1:0] ST_FIRST_WAIT = 4'd9;
    localparam logic [STEP_W-1:0] ST_FIRST_SET  = 4'd10;
    localparam logic [STEP_W-1:0] ST_CAND_MUL   = 4'd11;
    localparam logic [STEP_W-1:0] ST_CAND_DIV   = 4'd12;
    localparam logic [STEP_W-1:0] ST_CAND_WAIT  = 4'd13;
    localparam logic [STEP_W-1:0] ST_CAND_SET   = 4'd14;
    localparam logic [STEP_W-1:0] ST_OUTPUT     = 4'd15;

    // Control program. A taken condition jumps to target, otherwise the
    // step counter advances by one (the last step wraps to idle).
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t uw;
        case (step)
            ST_IDLE:       uw = '{OP_ACCUM,     COND_NO_START,   ST_IDLE};
            ST_AVG_DIV:    uw = '{OP_DIV_AVG,   COND_NONE,       ST_IDLE};
            ST_AVG_WAIT:   uw = '{OP_NOP,       COND_DIV_BUSY,   ST_AVG_WAIT};
            ST_MV_MUL:     uw = '{OP_MUL_MV,    COND_NONE,       ST_IDLE};
            ST_MV_DIV:     uw = '{OP_DIV_MV,    COND_NONE,       ST_IDLE};
            ST_MV_WAIT:    uw = '{OP_NOP,       COND_DIV_BUSY,   ST_MV_WAIT};
            ST_MV_SET:     uw = '{OP_SET_MV,    COND_FIRST_DONE, ST_CAND_MUL};
            ST_FIRST_MUL:  uw = '{OP_MUL_FIRST, COND_NONE,       ST_IDLE};
            ST_FIRST_DIV:  uw = '{OP_DIV_FIRST, COND_NONE,       ST_IDLE};
            ST_FIRST_WAIT: uw = '{OP_NOP,       COND_DIV_BUSY,   ST_FIRST_WAIT};
            ST_FIRST_SET:  uw = '{OP_SET_FIRST, COND_ALWAYS,     ST_OUTPUT};
            ST_CAND_MUL:   uw = '{OP_MUL_CAND,  COND_NONE,       ST_IDLE};
            ST_CAND_DIV:   uw = '{OP_DIV_CAND,  COND_NONE,       ST_IDLE};
            ST_CAND_WAIT:  uw = '{OP_NOP,       COND_DIV_BUSY,   ST_CAND_WAIT};
            ST_CAND_SET:   uw = '{OP_SET_CAND,  COND_NONE,       ST_IDLE};
            ST_OUTPUT:     uw = '{OP_OUTPUT,    COND_OUT_BUSY,   ST_OUTPUT};
            default:       uw = '{OP_NOP,       COND_ALWAYS,     ST_IDLE};
        endcase
        return uw;
    endfunction

endpackage

// ===== rtl/ble_divider.sv =====
// ----------------------------------------------------------------------------
// ble_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ble_divider #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 13
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;   // dividend shifts out, quotient shifts in

    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
            rem_reg  <= '0;
            den_reg  <= den;
            quo_reg  <= num;
        end else if (busy_reg) begin
            rem_reg  <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_reg  <= {quo_reg[NUM_W-2:0], fits};
            cnt_reg  <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign quot = quo_reg;

endmodule

// ===== rtl/ble_sequencer.sv =====
// ----------------------------------------------------------------------------
// ble_sequencer
// Step counter and microcode fetch with conditional jumps.
// ----------------------------------------------------------------------------
module ble_sequencer (
    input  logic             aclk,
    input  logic             aresetn,
    input  ble_pkg::status_t status,
    output ble_pkg::ctrl_t   ctrl
);

    logic [ble_pkg::STEP_W-1:0] step_reg;
    logic [ble_pkg::STEP_W-1:0] step_next;
    ble_pkg::ucode_t            uw;
    logic                       take;

    always_comb begin
        uw = ble_pkg::ucode_rom(step_reg);
        case (uw.cond)
            ble_pkg::COND_NONE:       take = 1'b0;
            ble_pkg::COND_ALWAYS:     take = 1'b1;
            ble_pkg::COND_NO_START:   take = !status.start;
            ble_pkg::COND_DIV_BUSY:   take = status.div_busy;
            ble_pkg::COND_FIRST_DONE: take = status.first_done;
            ble_pkg::COND_OUT_BUSY:   take = status.out_busy;
            default:                  take = 1'b0;
        endcase
        // last step wraps to idle through the counter overflow
        step_next = take ? uw.target : step_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ble_pkg::ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    assign ctrl.op   = uw.op;
    assign ctrl.idle = (step_reg == ble_pkg::ST_IDLE);

endmodule

// ===== rtl/ble_datapath.sv =====
// ----------------------------------------------------------------------------
// ble_datapath
// Config registers, burst accumulator, shared multiplier, level state and
// output register, all driven by the microcode op.
// ----------------------------------------------------------------------------
module ble_datapath #(
    parameter  int MAX_BURST   = ble_pkg::MAX_BURST_DEF,
    parameter  int SAMPLE_BITS = ble_pkg::SAMPLE_BITS_DEF,
    localparam int DEN_W = (SAMPLE_BITS > ble_pkg::CFG_W) ? SAMPLE_BITS : ble_pkg::CFG_W
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ble_pkg::ctrl_t                  ctrl,
    output ble_pkg::status_t                status,
    // config
    input  logic                            cfg_we,
    input  logic [ble_pkg::REG_IDX_W-1:0]   cfg_addr,
    input  logic [ble_pkg::CFG_W-1:0]       cfg_wdata,
    // samples
    input  logic                            s_valid,
    input  logic [ble_pkg::SAMPLE_W-1:0]    s_sample,
    input  logic                            s_last_in_burst,
    // divider
    output logic                            div_start,
    output logic [ble_pkg::PROD_W-1:0]      div_num,
    output logic [DEN_W-1:0]                div_den,
    input  logic                            div_busy,
    input  logic [ble_pkg::PROD_W-1:0]      div_quot,
    // results
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ble_pkg::CFG_W-1:0]       m_voltage_mv,
    output logic [ble_pkg::PCT_W-1:0]       m_percent,
    output logic                            m_charging
);

    localparam int CNT_W = $clog2(MAX_BURST + 1);
    localparam int SUM_W = ble_pkg::SAMPLE_W + CNT_W;
    localparam logic [DEN_W-1:0] ADC_MAX   = DEN_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [CNT_W-1:0] BURST_MAX = CNT_W'(MAX_BURST);

    // config registers
    logic [ble_pkg::CFG_W-1:0]   full_scale_reg;
    logic [ble_pkg::CFG_W-1:0]   empty_reg;
    logic [ble_pkg::CFG_W-1:0]   full_reg;
    logic [ble_pkg::TICKS_W-1:0] ticks_reg;

    // algorithm state
    logic [SUM_W-1:0]            sum_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        first_done_reg;
    logic [ble_pkg::LEVEL_W-1:0] prev_cand_reg;
    logic [ble_pkg::TICKS_W-1:0] repeat_reg;
    logic [ble_pkg::LEVEL_W-1:0] adopted_reg;
    logic [ble_pkg::CFG_W-1:0]   mv_reg;
    logic [ble_pkg::PROD_W-1:0]  prod_reg;

    // output register
    logic                        m_valid_reg;
    logic [ble_pkg::CFG_W-1:0]   m_voltage_mv_reg;
    logic [ble_pkg::PCT_W-1:0]   m_percent_reg;
    logic                        m_charging_reg;

    logic                        accept;
    logic                        out_busy;
    logic [ble_pkg::SAMPLE_W-1:0] s_sat;
    logic [ble_pkg::CFG_W-1:0]   mul_a;
    logic [ble_pkg::CFG_W-1:0]   mul_b;
    logic [ble_pkg::PROD_W-1:0]  mul_p;
    logic                        mv_above;
    logic                        span_ok;
    logic [ble_pkg::LEVEL_W-1:0] q_level;
    logic [ble_pkg::CFG_W-1:0]   q_mv;
    logic [ble_pkg::LEVEL_W-1:0] cand;
    logic [ble_pkg::TICKS_W-1:0] repeat_inc;

    assign accept   = s_valid && ctrl.idle;
    assign out_busy = m_valid_reg && !m_ready;

    assign status.start      = accept && s_last_in_burst;
    assign status.div_busy   = div_busy;
    assign status.first_done = first_done_reg;
    assign status.out_busy   = out_busy;

    // clip codes above the ADC range (only bites for narrow ADCs)
    assign s_sat = (DEN_W'(s_sample) > ADC_MAX) ? ADC_MAX[ble_pkg::SAMPLE_W-1:0] : s_sample;

    assign mv_above = mv_reg > empty_reg;
    assign span_ok  = full_reg > empty_reg;

    assign q_level = (div_quot > ble_pkg::PROD_W'(ble_pkg::LEVEL_SAT)) ?
                     ble_pkg::LEVEL_SAT : div_quot[ble_pkg::LEVEL_W-1:0];
    assign q_mv    = (div_quot > ble_pkg::PROD_W'(ble_pkg::MV_MAX)) ?
                     ble_pkg::MV_MAX : div_quot[ble_pkg::CFG_W-1:0];
    assign cand    = (span_ok && mv_above) ? q_level : '0;
    assign repeat_inc = (repeat_reg == ble_pkg::REPEAT_MAX) ? repeat_reg : repeat_reg + 1'b1;

    // shared multiplier operand select
    always_comb begin
        case (ctrl.op)
            ble_pkg::OP_MUL_MV: begin
                mul_a = div_quot[ble_pkg::CFG_W-1:0];   // average fits 12 bits
                mul_b = full_scale_reg;
            end
            ble_pkg::OP_MUL_FIRST: begin
                mul_a = mv_reg;
                mul_b = ble_pkg::PCT_FULL;
            end
            ble_pkg::OP_MUL_CAND: begin
                mul_a = mv_above ? mv_reg - empty_reg : '0;
                mul_b = ble_pkg::PCT_FULL;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = ble_pkg::PROD_W'(mul_a) * ble_pkg::PROD_W'(mul_b);
    end

    // divider operand select
    always_comb begin
        div_start = 1'b0;
        div_num   = prod_reg;
        div_den   = ADC_MAX;
        case (ctrl.op)
            ble_pkg::OP_DIV_AVG: begin
                div_start = 1'b1;
                div_num   = ble_pkg::PROD_W'(sum_reg);
                div_den   = DEN_W'(cnt_reg);
            end
            ble_pkg::OP_DIV_MV: begin
                div_start = 1'b1;
            end
            ble_pkg::OP_DIV_FIRST: begin
                div_start = 1'b1;
                div_den   = DEN_W'(full_reg);
            end
            ble_pkg::OP_DIV_CAND: begin
                div_start = 1'b1;
                div_den   = DEN_W'(full_reg - empty_reg);   // unused result if span <= 0
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // config port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_scale_reg <= ble_pkg::FULL_SCALE_RST;
            empty_reg      <= ble_pkg::EMPTY_RST;
            full_reg       <= ble_pkg::FULL_RST;
            ticks_reg      <= ble_pkg::TICKS_RST;
        end else if (cfg_we) begin
            case (ble_pkg::reg_idx_t'(cfg_addr))
                ble_pkg::REG_FULL_SCALE: full_scale_reg <= cfg_wdata;
                ble_pkg::REG_EMPTY:      empty_reg      <= cfg_wdata;
                ble_pkg::REG_FULL:       full_reg       <= cfg_wdata;
                ble_pkg::REG_TICKS:      ticks_reg      <= cfg_wdata[ble_pkg::TICKS_W-1:0];
                default:                 ;
            endcase
        end
    end

    // datapath ops
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg        <= '0;
            cnt_reg        <= '0;
            first_done_reg <= 1'b0;
            prev_cand_reg  <= '0;
            repeat_reg     <= '0;
            adopted_reg    <= '0;
            mv_reg         <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (ctrl.op)
                ble_pkg::OP_ACCUM: begin
                    // samples past the burst limit are dropped
                    if (accept && (cnt_reg < BURST_MAX)) begin
                        sum_reg <= sum_reg + SUM_W'(s_sat);
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ble_pkg::OP_DIV_AVG: begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end
                ble_pkg::OP_MUL_MV, ble_pkg::OP_MUL_FIRST, ble_pkg::OP_MUL_CAND: begin
                    prod_reg <= mul_p;
                end
                ble_pkg::OP_SET_MV: begin
                    mv_reg <= q_mv;
                end
                ble_pkg::OP_SET_FIRST: begin
                    adopted_reg    <= (full_reg == '0) ? '0 : q_level;
                    first_done_reg <= 1'b1;
                end
                ble_pkg::OP_SET_CAND: begin
                    if (cand != prev_cand_reg) begin
                        repeat_reg <= '0;
                    end else begin
                        repeat_reg <= repeat_inc;
                        if (repeat_inc >= ticks_reg) begin
                            adopted_reg <= cand;
                        end
                    end
                    prev_cand_reg <= cand;
                end
                ble_pkg::OP_OUTPUT: begin
                    if (!out_busy) begin
                        m_valid_reg      <= 1'b1;
                        m_voltage_mv_reg <= mv_reg;
                        if (adopted_reg >= ble_pkg::LEVEL_W'(ble_pkg::PCT_FULL)) begin
                            m_percent_reg  <= ble_pkg::PCT_W'(ble_pkg::PCT_FULL);
                            m_charging_reg <= 1'b1;
                        end else begin
                            m_percent_reg  <= adopted_reg[ble_pkg::PCT_W-1:0];
                            m_charging_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_voltage_mv = m_voltage_mv_reg;
    assign m_percent    = m_percent_reg;
    assign m_charging   = m_charging_reg;

endmodule

// ===== rtl/battery_level_estimator.sv =====
// Flow: a sample without the last-in-burst flag is only accumulated; a flagged
//   sample yields its result after the avg, mv, percent and output steps.
// Per burst: three passes of the shared restoring divider set the time taken;
//   no sample is taken while a burst end is being evaluated.
// Reset (aresetn low, synchronous): config returns to 6600/3200/4200/10,
//   accumulator and level history clear, first burst is treated as first again.
// ----------------------------------------------------------------------------
// battery_level_estimator
// Averages ADC sample bursts, scales to millivolts and tracks a debounced
// charge percent.
// ----------------------------------------------------------------------------
//
// Structure
//   ble_sequencer : 4-bit step counter over a 16-word microcode ROM. Each
//                   word carries a datapath op, a jump condition and target.
//   ble_datapath  : config registers, burst accumulator, one 13x13 multiplier,
//                   level/debounce state and the result register.
//   ble_divider   : one quotient bit per cycle, shared by all three divides
//                   (sum/count, avg*fs/ADC_MAX, percent scaling).
//
// Program outline
//   idle      : accumulate each accepted sample; a flagged one starts the run
//   avg       : sum / count, accumulator cleared
//   mv        : avg * full_scale_mv / ADC_MAX, clipped to 8191
//   first     : mv * 100 / full_mv (0 if full_mv is 0), adopted at once
//   candidate : (mv - empty) * 100 / (full - empty), 0 if mv or span not above
//               empty; adopted after the same value repeats stable_ticks times
//   output    : waits for the result register to drain, then loads it
//
// s_ready is high only while the sequencer sits at idle. The result register
// decouples m_ready: the next burst accumulates while a result waits.
// ----------------------------------------------------------------------------
module battery_level_estimator #(
    parameter int MAX_BURST   = ble_pkg::MAX_BURST_DEF,
    parameter int SAMPLE_BITS = ble_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // config write port
    input  logic                           cfg_we,
    input  logic [ble_pkg::REG_IDX_W-1:0]  cfg_addr,
    input  logic [ble_pkg::CFG_W-1:0]      cfg_wdata,
    // sample transactions
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ble_pkg::SAMPLE_W-1:0]   s_sample,
    input  logic                           s_last_in_burst,
    // result transactions
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ble_pkg::CFG_W-1:0]      m_voltage_mv,
    output logic [ble_pkg::PCT_W-1:0]      m_percent,
    output logic                           m_charging
);

    // divisor must hold both ADC_MAX and the 13-bit millivolt registers
    localparam int DEN_W = (SAMPLE_BITS > ble_pkg::CFG_W) ? SAMPLE_BITS : ble_pkg::CFG_W;

    ble_pkg::ctrl_t              ctrl;
    ble_pkg::status_t            status;
    logic                        div_start;
    logic [ble_pkg::PROD_W-1:0]  div_num;
    logic [DEN_W-1:0]            div_den;
    logic                        div_busy;
    logic [ble_pkg::PROD_W-1:0]  div_quot;

    assign s_ready = ctrl.idle;

    ble_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    ble_datapath #(
        .MAX_BURST   (MAX_BURST),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_sample        (s_sample),
        .s_last_in_burst (s_last_in_burst),
        .div_start       (div_start),
        .div_num         (div_num),
        .div_den         (div_den),
        .div_busy        (div_busy),
        .div_quot        (div_quot),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_voltage_mv    (m_voltage_mv),
        .m_percent       (m_percent),
        .m_charging      (m_charging)
    );

    ble_divider #(
        .NUM_W (ble_pkg::PROD_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (div_quot)
    );

endmodule

// ===== rtl/ble_checker.sv =====
// ----------------------------------------------------------------------------
// ble_checker
// Port-level checks on the battery level estimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "battery_level_estimator_macros.svh"

module ble_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         s_last_in_burst,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [ble_pkg::CFG_W-1:0]    m_voltage_mv,
    input logic [ble_pkg::PCT_W-1:0]    m_percent,
    input logic                         m_charging
);

    // stalled result transaction holds
    `BLE_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_voltage_mv) && $stable(m_percent) && $stable(m_charging), "result changed while stalled")

    // burst end starts evaluation, input closes
    `BLE_ASSERT_NEXT(a_busy_after_last, s_valid && s_ready && s_last_in_burst, !s_ready, "input still open after burst end")

    `BLE_ASSERT_NOW(a_pct_range, m_valid, m_percent <= ble_pkg::PCT_W'(ble_pkg::PCT_FULL), "percent above 100")

    `BLE_ASSERT_NOW(a_charging, m_valid, m_charging == (m_percent == ble_pkg::PCT_W'(ble_pkg::PCT_FULL)), "charging flag disagrees with percent")

endmodule

bind battery_level_estimator ble_checker u_ble_checker (.*);
